### rtl/core/wrs_pkg.sv
package wrs_pkg;

   // Field widths of the report, the result and the register file.
   localparam int DIR_W       = 16;
   localparam int WSPEED_W    = 13;
   localparam int SPEED_W     = 12;
   localparam int HDG_W       = 12;
   localparam int SLOT_W      = 2;
   localparam int COUNT_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   // Angle arithmetic in tenths of a degree.
   localparam int ANGLE_W = 10;
   localparam logic [HDG_W-1:0] FULL_TURN    = 12'd3600;
   localparam logic [HDG_W-1:0] HALF_TURN    = 12'd1800;
   localparam logic [HDG_W-1:0] QUARTER_TURN = 12'd900;
   localparam logic [HDG_W-1:0] DEFAULT_HDG_A = 12'd900;
   localparam logic [HDG_W-1:0] DEFAULT_HDG_B = 12'd2700;
   localparam logic [CSR_DATA_W-1:0] MARGIN_RESET = 12'd80;

   // Ten full turns lift any signed 16-bit direction into positive range.
   localparam logic [16:0] DIR_LIFT = 17'd36000;
   // floor(v / 3600) = (v * WRAP_RECIP) >> WRAP_SHIFT for v below 2^17.
   localparam logic [17:0] WRAP_RECIP = 18'd149131;
   localparam int          WRAP_SHIFT = 29;

   // Sine in Q14, score and dead-band widths.
   localparam int SINE_STAGES = 7;
   localparam int SINE_W      = 15;
   localparam int DIFF_W      = 17;
   localparam int SCORE_W     = 28;
   localparam int GAP_W       = SCORE_W + 1;
   localparam int Q14_SHIFT   = 14;
   localparam logic [SINE_W-1:0] Q14_ONE = 15'd16384;

   typedef logic signed [SCORE_W-1:0] score_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RUNWAY_COUNT  = 3'd0,
      CSR_HEADING_ZERO  = 3'd1,
      CSR_HEADING_ONE   = 3'd2,
      CSR_HEADING_TWO   = 3'd3,
      CSR_HEADING_THREE = 3'd4,
      CSR_SWITCH_MARGIN = 3'd5
   } csr_index_type;

endpackage

### rtl/core/wrs_req_if.sv
interface wrs_req_if
   import wrs_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [DIR_W-1:0]   wind_dir;
   logic signed [WSPEED_W-1:0] wind_speed;
   logic                      restart;

   modport source (output valid, output wind_dir, output wind_speed, output restart,
                   input ready);
   modport sink   (input valid, input wind_dir, input wind_speed, input restart,
                   output ready);
endinterface

### rtl/core/wrs_rsp_if.sv
interface wrs_rsp_if
   import wrs_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] active_slot;
   logic [HDG_W-1:0]  active_heading;
   logic              changed;
   logic              held;

   modport source (output valid, output active_slot, output active_heading,
                   output changed, output held, input ready);
   modport sink   (input valid, input active_slot, input active_heading,
                   input changed, input held, output ready);
endinterface

### rtl/core/wrs_sine.sv
module wrs_sine
   import wrs_pkg::*;
(
   input  logic                   clock,
   input  logic [SINE_STAGES-1:0] en,
   input  logic [ANGLE_W-1:0]     x,
   output logic [SINE_W-1:0]      s
);

   // Stage 1: t = floor((x*65536 + 450) / 900) = 72x + floor((736x + 450) / 900).
   logic [19:0] frac_num;
   logic [40:0] frac_prod;
   logic [ANGLE_W-1:0] x1_ff;
   logic [9:0]  tq1_ff;

   // Stage 2 onward.
   logic [16:0] t_in;
   logic [33:0] tt_in;
   logic [16:0] t2_ff;
   logic [33:0] tt2_ff;

   logic [16:0] sq_in;
   logic [25:0] m1_in;
   logic [16:0] t3_ff;
   logic [16:0] sq3_ff;
   logic [25:0] m1_3_ff;

   logic [25:0] rnd1;
   logic [12:0] a_in;
   logic [29:0] m2_in;
   logic [16:0] t4_ff;
   logic [16:0] sq4_ff;
   logic [29:0] m2_4_ff;

   logic [29:0] rnd2;
   logic [15:0] b_in;
   logic [32:0] m3_in;
   logic [16:0] t5_ff;
   logic [32:0] m3_5_ff;

   logic [32:0] rnd3;
   logic [16:0] c_in;
   logic [33:0] m4_in;
   logic [33:0] m4_6_ff;

   logic [33:0] r4;
   logic [SINE_W-1:0] s_in;
   logic [SINE_W-1:0] s_ff;

   always_comb begin
      frac_num  = 20'(x) * 20'd736 + 20'd450;
      frac_prod = 41'(frac_num) * 41'(21'd1193047);

      t_in  = 17'(x1_ff) * 17'd72 + 17'(tq1_ff);
      tt_in = 34'(t_in) * 34'(t_in);

      sq_in = 17'((tt2_ff + 34'd32768) >> 16);
      m1_in = 26'(sq_in) * 26'd297;

      rnd1  = (m1_3_ff + 26'd32768) >> 16;
      a_in  = 13'd5223 - 13'(rnd1);
      m2_in = 30'(sq3_ff) * 30'(a_in);

      rnd2  = (m2_4_ff + 30'd32768) >> 16;
      b_in  = 16'd42334 - 16'(rnd2);
      m3_in = 33'(sq4_ff) * 33'(b_in);

      rnd3  = (m3_5_ff + 33'd32768) >> 16;
      c_in  = 17'd102944 - 17'(rnd3);
      m4_in = 34'(t5_ff) * 34'(c_in);

      r4   = (m4_6_ff + 34'd131072) >> 18;
      s_in = (r4 > 34'(Q14_ONE)) ? Q14_ONE : SINE_W'(r4);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x1_ff  <= x;
         tq1_ff <= frac_prod[39:30];
      end
      if (en[1]) begin
         t2_ff  <= t_in;
         tt2_ff <= tt_in;
      end
      if (en[2]) begin
         t3_ff   <= t2_ff;
         sq3_ff  <= sq_in;
         m1_3_ff <= m1_in;
      end
      if (en[3]) begin
         t4_ff   <= t3_ff;
         sq4_ff  <= sq3_ff;
         m2_4_ff <= m2_in;
      end
      if (en[4]) begin
         t5_ff   <= t4_ff;
         m3_5_ff <= m3_in;
      end
      if (en[5]) begin
         m4_6_ff <= m4_in;
      end
      if (en[6]) begin
         s_ff <= s_in;
      end
   end

   assign s = s_ff;

endmodule

### rtl/core/wind_runway_selector.sv
// Runway selector: each wind report beat on req_bus yields exactly one result beat on
// rsp_bus, in order. A report is accepted in every cycle while the pipeline has room,
// and its result passes through the fixed pipeline: input register, direction
// wrap (two stages), angle folding, seven stages of the Q14 sine polynomial per runway
// for both |sin| and cos, the score multiply, the minimum search and the output
// register, where the dead-band decision and the active-runway state live. Each stage
// moves on as soon as the next one has room, so stalls on rsp_bus fill the pipeline
// before req_bus is held off. Registers on the csr port are written at any edge with
// csr_we high and must only change while no report is in flight; writing the runway
// count or a heading forces a fresh pick on the next report. A runway count of zero
// selects the default 090/270 pair.
module wind_runway_selector
   import wrs_pkg::*;
#(
   parameter int MAX_RUNWAYS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   wrs_req_if.sink                req_bus,
   wrs_rsp_if.source              rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int LIMIT  = (MAX_RUNWAYS < 4) ? MAX_RUNWAYS : 4;
   localparam int LANES  = (LIMIT < 2) ? 2 : LIMIT;
   localparam int LIDX_W = $clog2(LANES);

   localparam int ST_IN    = 0;
   localparam int ST_WRAP  = 1;
   localparam int ST_WIND  = 2;
   localparam int ST_ANG   = 3;
   localparam int ST_SIN0  = 4;
   localparam int ST_SCORE = ST_SIN0 + SINE_STAGES;
   localparam int ST_MIN   = ST_SCORE + 1;
   localparam int ST_OUT   = ST_MIN + 1;
   localparam int NST      = ST_OUT + 1;

   // Configuration registers.
   logic [COUNT_W-1:0]    runway_count_ff;
   logic [HDG_W-1:0]      heading_ff [4];
   logic [CSR_DATA_W-1:0] margin_ff;

   // Pipeline control.
   logic [NST-1:0] valid_ff;
   logic [NST-1:0] adv;

   // Payload along the pipeline.
   logic signed [DIR_W-1:0] dir0_ff;
   logic [SPEED_W-1:0]      speed_p_ff [ST_SCORE];
   logic                    restart_p_ff [ST_OUT];
   logic [LANES-1:0]        cneg_p_ff [ST_ANG:ST_SCORE-1];

   logic [16:0] lift_in;
   logic [34:0] wrap_prod;
   logic [16:0] v1_ff;
   logic [4:0]  q1_ff;
   logic [HDG_W-1:0] wind2_in;
   logic [HDG_W-1:0] wind2_ff;

   // Effective runway list.
   logic [COUNT_W-1:0] n_lim;
   logic [COUNT_W-1:0] n_eff;
   logic [HDG_W-1:0]   hdg_eff [LANES];
   logic [LANES-1:0]   lane_on;

   // Angle folding per lane.
   logic [12:0]        ang_sum [LANES];
   logic [HDG_W-1:0]   ang_d   [LANES];
   logic [HDG_W-1:0]   ang_u   [LANES];
   logic [HDG_W-1:0]   ang_e   [LANES];
   logic [ANGLE_W-1:0] xs_in   [LANES];
   logic [ANGLE_W-1:0] xc_in   [LANES];
   logic [LANES-1:0]   cneg_in;
   logic [ANGLE_W-1:0] xs_ff   [LANES];
   logic [ANGLE_W-1:0] xc_ff   [LANES];

   logic [SINE_W-1:0] sin_q [LANES];
   logic [SINE_W-1:0] cos_q [LANES];

   // Scores, minimum and decision.
   logic signed [DIFF_W-1:0] diff_in  [LANES];
   score_type                score_in [LANES];
   score_type                score_ff [LANES];
   score_type                score_min_ff [LANES];

   logic [LIDX_W-1:0] best_idx_in;
   score_type         best_sc_in;
   logic [LIDX_W-1:0] best_idx_ff;
   score_type         best_sc_ff;

   logic                    active_known_ff;
   logic [HDG_W-1:0]        current_heading_ff;
   logic [SLOT_W-1:0]       current_slot_ff;

   logic                    known_eff;
   logic [HDG_W-1:0]        best_hdg;
   score_type               cur_sc;
   logic signed [GAP_W-1:0] gap;
   logic signed [GAP_W-1:0] margin_q;
   logic                    hold;

   logic [SLOT_W-1:0] slot_ff;
   logic [HDG_W-1:0]  hdg_ff;
   logic              changed_ff;
   logic              held_ff;

   // ---------------------------------------------------------------- handshake
   always_comb begin
      adv[NST-1] = !valid_ff[NST-1] || rsp_bus.ready;
      for (int k = NST - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_bus.ready = adv[ST_IN];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[ST_IN]) begin
            valid_ff[ST_IN] <= req_bus.valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         runway_count_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            heading_ff[i] <= '0;
         end
         margin_ff <= MARGIN_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_RUNWAY_COUNT:  runway_count_ff <= csr_data[COUNT_W-1:0];
            CSR_HEADING_ZERO:  heading_ff[0] <= csr_data;
            CSR_HEADING_ONE:   heading_ff[1] <= csr_data;
            CSR_HEADING_TWO:   heading_ff[2] <= csr_data;
            CSR_HEADING_THREE: heading_ff[3] <= csr_data;
            CSR_SWITCH_MARGIN: margin_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Headings are taken modulo one turn; a count of zero means the default pair.
   always_comb begin
      n_lim = (runway_count_ff > COUNT_W'(LIMIT)) ? COUNT_W'(LIMIT) : runway_count_ff;
      n_eff = (n_lim == '0) ? COUNT_W'(2) : n_lim;
      for (int i = 0; i < LANES; i++) begin
         if (n_lim == '0) begin
            hdg_eff[i] = (i == 0) ? DEFAULT_HDG_A : DEFAULT_HDG_B;
         end else begin
            hdg_eff[i] = (heading_ff[i] >= FULL_TURN) ? heading_ff[i] - FULL_TURN
                                                      : heading_ff[i];
         end
         lane_on[i] = COUNT_W'(i) < n_eff;
      end
   end

   // ---------------------------------------------------------------- front end
   always_comb begin
      lift_in   = 17'(dir0_ff) + DIR_LIFT;
      wrap_prod = 35'(lift_in) * 35'(WRAP_RECIP);
      wind2_in  = HDG_W'(v1_ff - 17'(q1_ff) * 17'(FULL_TURN));
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         ang_sum[i] = 13'(wind2_ff) + 13'(FULL_TURN) - 13'(hdg_eff[i]);
         ang_d[i]   = (ang_sum[i] >= 13'(FULL_TURN)) ? HDG_W'(ang_sum[i] - 13'(FULL_TURN))
                                                     : HDG_W'(ang_sum[i]);
         ang_u[i]   = (ang_d[i] >= HALF_TURN) ? ang_d[i] - HALF_TURN : ang_d[i];
         xs_in[i]   = (ang_u[i] <= QUARTER_TURN) ? ANGLE_W'(ang_u[i])
                                                 : ANGLE_W'(HALF_TURN - ang_u[i]);
         ang_e[i]   = (ang_d[i] > HALF_TURN) ? FULL_TURN - ang_d[i] : ang_d[i];
         cneg_in[i] = ang_e[i] > QUARTER_TURN;
         xc_in[i]   = cneg_in[i] ? ANGLE_W'(ang_e[i] - QUARTER_TURN)
                                 : ANGLE_W'(QUARTER_TURN - ang_e[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_IN]) begin
         dir0_ff <= req_bus.wind_dir;
         speed_p_ff[ST_IN] <= req_bus.wind_speed[WSPEED_W-1] ? '0
                                                             : req_bus.wind_speed[SPEED_W-1:0];
         restart_p_ff[ST_IN] <= req_bus.restart;
      end
      for (int k = 1; k < ST_SCORE; k++) begin
         if (adv[k]) begin
            speed_p_ff[k] <= speed_p_ff[k-1];
         end
      end
      for (int k = 1; k < ST_OUT; k++) begin
         if (adv[k]) begin
            restart_p_ff[k] <= restart_p_ff[k-1];
         end
      end
      if (adv[ST_WRAP]) begin
         v1_ff <= lift_in;
         q1_ff <= wrap_prod[WRAP_SHIFT+4:WRAP_SHIFT];
      end
      if (adv[ST_WIND]) begin
         wind2_ff <= wind2_in;
      end
      if (adv[ST_ANG]) begin
         for (int i = 0; i < LANES; i++) begin
            xs_ff[i] <= xs_in[i];
            xc_ff[i] <= xc_in[i];
         end
         cneg_p_ff[ST_ANG] <= cneg_in;
      end
      for (int k = ST_ANG + 1; k < ST_SCORE; k++) begin
         if (adv[k]) begin
            cneg_p_ff[k] <= cneg_p_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- sine units
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      wrs_sine u_sin (
         .clock (clock),
         .en    (adv[ST_SIN0 +: SINE_STAGES]),
         .x     (xs_ff[g]),
         .s     (sin_q[g])
      );
      wrs_sine u_cos (
         .clock (clock),
         .en    (adv[ST_SIN0 +: SINE_STAGES]),
         .x     (xc_ff[g]),
         .s     (cos_q[g])
      );
   end

   // ---------------------------------------------------------------- scores
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         diff_in[i] = cneg_p_ff[ST_SCORE-1][i]
                    ? $signed(DIFF_W'(sin_q[i])) + $signed(DIFF_W'(cos_q[i]))
                    : $signed(DIFF_W'(sin_q[i])) - $signed(DIFF_W'(cos_q[i]));
         score_in[i] = SCORE_W'($signed({1'b0, speed_p_ff[ST_SCORE-1]}))
                     * SCORE_W'(diff_in[i]);
      end
   end

   // Strict less-than keeps the lower slot on a tie.
   always_comb begin
      best_idx_in = '0;
      best_sc_in  = score_ff[0];
      for (int i = 1; i < LANES; i++) begin
         if (lane_on[i] && (score_ff[i] < best_sc_in)) begin
            best_idx_in = LIDX_W'(i);
            best_sc_in  = score_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_SCORE]) begin
         for (int i = 0; i < LANES; i++) begin
            score_ff[i] <= score_in[i];
         end
      end
      if (adv[ST_MIN]) begin
         best_idx_ff <= best_idx_in;
         best_sc_ff  <= best_sc_in;
         for (int i = 0; i < LANES; i++) begin
            score_min_ff[i] <= score_ff[i];
         end
      end
   end

   // ---------------------------------------------------------------- decision
   // While a runway is active it sits at current_slot of the unchanged list, so its
   // score is already among the lane scores.
   always_comb begin
      known_eff = active_known_ff && !restart_p_ff[ST_MIN];
      best_hdg  = hdg_eff[best_idx_ff];
      cur_sc    = score_min_ff[current_slot_ff[LIDX_W-1:0]];
      gap       = GAP_W'(cur_sc) - GAP_W'(best_sc_ff);
      margin_q  = $signed(GAP_W'({margin_ff, Q14_SHIFT'(0)}));
      hold      = known_eff && (best_hdg != current_heading_ff) && (gap < margin_q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_known_ff    <= 1'b0;
         current_heading_ff <= '0;
         current_slot_ff    <= '0;
      end else begin
         if (adv[ST_OUT] && valid_ff[ST_MIN]) begin
            active_known_ff <= 1'b1;
            if (!hold) begin
               current_heading_ff <= best_hdg;
               current_slot_ff    <= SLOT_W'(best_idx_ff);
            end
         end
         if (csr_we && (csr_index <= CSR_HEADING_THREE)) begin
            active_known_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         if (hold) begin
            slot_ff    <= current_slot_ff;
            hdg_ff     <= current_heading_ff;
            changed_ff <= 1'b0;
            held_ff    <= 1'b1;
         end else begin
            slot_ff    <= SLOT_W'(best_idx_ff);
            hdg_ff     <= best_hdg;
            changed_ff <= !known_eff || (best_hdg != current_heading_ff);
            held_ff    <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid          = valid_ff[ST_OUT];
   assign rsp_bus.active_slot    = slot_ff;
   assign rsp_bus.active_heading = hdg_ff;
   assign rsp_bus.changed        = changed_ff;
   assign rsp_bus.held           = held_ff;

endmodule

### rtl/core/wrs_checker.sv
module wrs_checker
   import wrs_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SLOT_W-1:0]      rsp_slot,
   input logic [HDG_W-1:0]       rsp_heading,
   input logic                   rsp_changed,
   input logic                   rsp_held,
   input logic                   csr_we,
   input logic [CSR_INDEX_W-1:0] csr_index
);

   logic             beat;
   logic             seen_ff;
   logic             fresh_ff;
   logic [HDG_W-1:0] last_hdg_ff;

   assign beat = rsp_valid && rsp_ready;

   // A write to the count or a heading means the next result is a fresh pick.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= 1'b0;
         fresh_ff    <= 1'b1;
         last_hdg_ff <= '0;
      end else begin
         if (beat) begin
            seen_ff     <= 1'b1;
            fresh_ff    <= 1'b0;
            last_hdg_ff <= rsp_heading;
         end
         if (csr_we && (csr_index <= CSR_HEADING_THREE)) begin
            fresh_ff <= 1'b1;
         end
      end
   end

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_slot, rsp_heading, rsp_changed, rsp_held}))
      else $error("result payload moved while stalled");

   a_unchanged_keeps_heading: assert property (@(posedge clock) disable iff (reset)
      beat && !rsp_changed |-> seen_ff && (rsp_heading == last_hdg_ff))
      else $error("unchanged result reports a different heading");

   a_fresh_pick_changes: assert property (@(posedge clock) disable iff (reset)
      beat && fresh_ff |-> rsp_changed && !rsp_held)
      else $error("first result after reset or runway write is not a fresh pick");

endmodule

bind wind_runway_selector wrs_checker u_wrs_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_slot    (rsp_bus.active_slot),
   .rsp_heading (rsp_bus.active_heading),
   .rsp_changed (rsp_bus.changed),
   .rsp_held    (rsp_bus.held),
   .csr_we      (csr_we),
   .csr_index   (csr_index)
);

### sim/wind_runway_selector_tb.sv
module wind_runway_selector_tb;
   import wrs_pkg::*;

   localparam int RUNWAY_SLOTS   = 4;
   localparam int PIPE_LATENCY   = 13;
   localparam int STALL_LIMIT    = 1000;
   localparam int FULL_TENTHS    = 3600;
   localparam int HALF_TENTHS    = 1800;
   localparam int QUARTER_TENTHS = 900;
   localparam longint Q14_SCALE  = 16384;

   // Odd-order polynomial for the first-quadrant sine, Q16 coefficients.
   localparam longint SIN_C1 = 102944;
   localparam longint SIN_K3 = 42334;
   localparam longint SIN_C5 = 5223;
   localparam longint SIN_K7 = 297;

   // Register indexes the block does not decode.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_SIX   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_SEVEN = 3'd7;

   localparam logic signed [DIR_W-1:0]    DIR_MIN   = 16'sh8000;
   localparam logic signed [DIR_W-1:0]    DIR_MAX   = 16'sh7FFF;
   localparam logic signed [WSPEED_W-1:0] SPEED_MIN = 13'sh1000;
   localparam logic signed [WSPEED_W-1:0] SPEED_MAX = 13'sh0FFF;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [HDG_W-1:0]  heading;
      logic              changed;
      logic              held;
   } runway_pick_type;

   typedef struct {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } reg_write_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   wrs_req_if req_bus ();
   wrs_rsp_if rsp_bus ();

   wind_runway_selector #(.MAX_RUNWAYS(RUNWAY_SLOTS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Mirror of the register file and of the active-runway state.
   logic [COUNT_W-1:0]    cfg_count = '0;
   logic [HDG_W-1:0]      cfg_heading [RUNWAY_SLOTS] = '{default: '0};
   logic [CSR_DATA_W-1:0] cfg_margin = MARGIN_RESET;
   bit                    runway_known = 1'b0;
   int unsigned           active_hdg = 0;
   int unsigned           active_idx = 0;

   runway_pick_type pending_picks [$];
   reg_write_type   csr_batch [$];
   int              mismatch_count = 0;
   int              rsp_hold = 0;
   bit              req_steady = 1'b0;
   bit              rsp_steady = 1'b0;
   bit              req_flat = 1'b0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int unsigned quarter_sine(input int unsigned angle);
      longint t, t2, a, b, c, s, x;
      x  = (angle > QUARTER_TENTHS) ? QUARTER_TENTHS : angle;
      t  = (x * 65536 + 450) / 900;
      t2 = (t * t + 32768) >>> 16;
      a  = SIN_C5 - ((t2 * SIN_K7 + 32768) >>> 16);
      b  = SIN_K3 - ((t2 * a + 32768) >>> 16);
      c  = SIN_C1 - ((t2 * b + 32768) >>> 16);
      s  = (t * c + 131072) >>> 18;
      if (s > Q14_SCALE) s = Q14_SCALE;
      return int'(s);
   endfunction

   // Crosswind minus headwind, scaled by speed; lower is better.
   function automatic longint wind_cost(input int unsigned wind, input int unsigned hdg,
                                        input int unsigned speed);
      int unsigned d, u, x, e;
      longint      s, c;
      d = (wind + FULL_TENTHS - (hdg % FULL_TENTHS)) % FULL_TENTHS;
      u = (d >= HALF_TENTHS) ? d - HALF_TENTHS : d;
      x = (u <= QUARTER_TENTHS) ? u : HALF_TENTHS - u;
      e = (d > HALF_TENTHS) ? FULL_TENTHS - d : d;
      s = quarter_sine(x);
      if (e <= QUARTER_TENTHS) c = quarter_sine(QUARTER_TENTHS - e);
      else c = -longint'(quarter_sine(e - QUARTER_TENTHS));
      return longint'(speed) * (s - c);
   endfunction

   function automatic runway_pick_type pick_runway(input logic signed [DIR_W-1:0] dir,
                                                   input logic signed [WSPEED_W-1:0] speed,
                                                   input logic restart);
      int              wrapped, i;
      int unsigned     wind, spd, count, best_idx;
      int unsigned     hdgs [RUNWAY_SLOTS];
      longint          best_cost, cost;
      bit              keep;
      runway_pick_type pick;
      wrapped = int'(dir) % FULL_TENTHS;
      if (wrapped < 0) wrapped += FULL_TENTHS;
      wind = wrapped;
      spd  = speed[WSPEED_W-1] ? 0 : speed[WSPEED_W-2:0];
      if (restart) runway_known = 1'b0;

      count = (cfg_count > RUNWAY_SLOTS) ? RUNWAY_SLOTS : cfg_count;
      if (count == 0) begin
         hdgs[0] = DEFAULT_HDG_A;
         hdgs[1] = DEFAULT_HDG_B;
         count   = 2;
      end else begin
         for (i = 0; i < count; i++) hdgs[i] = cfg_heading[i] % FULL_TENTHS;
      end

      best_idx  = 0;
      best_cost = wind_cost(wind, hdgs[0], spd);
      for (i = 1; i < count; i++) begin
         cost = wind_cost(wind, hdgs[i], spd);
         if (cost < best_cost) begin
            best_cost = cost;
            best_idx  = i;
         end
      end

      keep = 1'b0;
      if (runway_known && hdgs[best_idx] != active_hdg) begin
         cost = wind_cost(wind, active_hdg, spd);
         keep = (cost - best_cost) < longint'(cfg_margin) * Q14_SCALE;
      end

      if (keep) begin
         pick = '{slot: SLOT_W'(active_idx), heading: HDG_W'(active_hdg),
                  changed: 1'b0, held: 1'b1};
      end else begin
         pick.changed = !runway_known || hdgs[best_idx] != active_hdg;
         pick.held    = 1'b0;
         runway_known = 1'b1;
         active_hdg   = hdgs[best_idx];
         active_idx   = best_idx;
         pick.slot    = SLOT_W'(active_idx);
         pick.heading = HDG_W'(active_hdg);
      end
      return pick;
   endfunction

   // Occasionally switches between random gaps and a stretch with none.
   function automatic int draw_wait(inout bit steady);
      if ($urandom_range(0, 31) == 0) steady = !steady;
      return steady ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic void stage_write(input logic [CSR_INDEX_W-1:0] index,
                                       input logic [CSR_DATA_W-1:0] data);
      reg_write_type w;
      w.index = index;
      w.data  = data;
      csr_batch.push_back(w);
   endfunction

   task automatic apply_writes();
      reg_write_type w;
      while (csr_batch.size() > 0) begin
         w = csr_batch.pop_front();
         csr_we    <= 1'b1;
         csr_index <= w.index;
         csr_data  <= w.data;
         @(posedge clock);
         case (w.index)
            CSR_RUNWAY_COUNT: begin
               cfg_count    = w.data[COUNT_W-1:0];
               runway_known = 1'b0;
            end
            CSR_HEADING_ZERO, CSR_HEADING_ONE, CSR_HEADING_TWO, CSR_HEADING_THREE: begin
               cfg_heading[w.index - CSR_HEADING_ZERO] = w.data;
               runway_known = 1'b0;
            end
            CSR_SWITCH_MARGIN: cfg_margin = w.data;
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // Every report yields a result, so an empty queue means nothing is in flight.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
   endtask

   task automatic send_report(input logic signed [DIR_W-1:0] dir,
                              input logic signed [WSPEED_W-1:0] speed,
                              input logic restart);
      int gap;
      gap = req_flat ? 0 : draw_wait(req_steady);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.wind_dir   <= dir;
      req_bus.wind_speed <= speed;
      req_bus.restart    <= restart;
      do @(posedge clock); while (!req_bus.ready);
      pending_picks.push_back(pick_runway(dir, speed, restart));
   endtask

   task automatic test_field_extremes();
      send_report(DIR_MIN, SPEED_MAX, 1'b0);
      send_report(DIR_MAX, SPEED_MAX, 1'b0);
      send_report(16'sd0, 13'sd0, 1'b0);
      send_report(16'sd900, SPEED_MIN, 1'b0);
      send_report(16'sd2700, -13'sd1, 1'b0);
      send_report(-16'sd1, 13'sd1, 1'b1);
      send_report(16'sd3600, 13'sd2000, 1'b0);
      send_report(-16'sd3600, SPEED_MAX, 1'b1);
   endtask

   // Default 090/270 pair with the reset margin: switch, hold, and a repeat pick.
   task automatic test_dead_band();
      send_report(16'sd900, 13'sd1600, 1'b1);
      send_report(16'sd2700, SPEED_MAX, 1'b0);
      send_report(16'sd0, 13'sd2000, 1'b0);
      send_report(16'sd880, 13'sd16, 1'b0);
      send_report(16'sd2700, 13'sd800, 1'b0);
      send_report(16'sd901, SPEED_MAX, 1'b0);
   endtask

   task automatic test_register_corners();
      // Oversized count, headings past a full turn and writes to spare indexes.
      wait_idle();
      stage_write(CSR_RUNWAY_COUNT, 12'hFFF);
      stage_write(CSR_HEADING_ZERO, 12'd4095);
      stage_write(CSR_HEADING_ONE, 12'd3600);
      stage_write(CSR_HEADING_TWO, 12'd3599);
      stage_write(CSR_HEADING_THREE, 12'd0);
      stage_write(CSR_SWITCH_MARGIN, 12'hFFF);
      stage_write(CSR_SPARE_SIX, 12'h000);
      stage_write(CSR_SPARE_SEVEN, 12'hFFF);
      apply_writes();
      send_report(16'sd495, SPEED_MAX, 1'b0);
      send_report(16'sd0, SPEED_MAX, 1'b0);
      send_report(16'sd1800, SPEED_MAX, 1'b0);

      wait_idle();
      stage_write(CSR_RUNWAY_COUNT, 12'd0);
      apply_writes();
      send_report(16'sd2700, 13'sd1000, 1'b0);
      send_report(16'sd900, 13'sd1000, 1'b0);

      // A margin write alone leaves the active runway in place.
      wait_idle();
      stage_write(CSR_SWITCH_MARGIN, 12'd0);
      apply_writes();
      send_report(16'sd2700, 13'sd1000, 1'b0);
      send_report(16'sd3000, 13'sd500, 1'b0);

      wait_idle();
      stage_write(CSR_RUNWAY_COUNT, 12'hFF9);
      stage_write(CSR_HEADING_ZERO, 12'd1234);
      apply_writes();
      send_report(16'sd100, 13'sd3000, 1'b0);
   endtask

   task automatic test_output_backpressure();
      int k;
      rsp_hold = 120;
      req_flat = 1'b1;
      for (k = 0; k < 40; k++) begin
         send_report(DIR_W'($urandom()), WSPEED_W'($urandom_range(0, 4095)), k == 0);
      end
      req_flat = 1'b0;
   endtask

   task automatic test_random_traffic(input int total);
      int phase, per_phase, sent, len, k, dir, spd, step_max;
      int unsigned count, margin;
      per_phase = total / 8;
      for (phase = 0; phase < 8; phase++) begin
         wait_idle();
         case (phase)
            0: begin count = 0; margin = 0; end
            1: begin count = 4; margin = 4095; end
            3: begin count = 7; margin = $urandom_range(0, 4095); end
            default: begin
               count = $urandom_range(0, 7);
               case ($urandom_range(0, 3))
                  0: margin = 0;
                  1: margin = 4095;
                  2: margin = $urandom_range(0, 400);
                  default: margin = $urandom_range(0, 4095);
               endcase
            end
         endcase
         if (phase != 2) begin
            stage_write(CSR_RUNWAY_COUNT,
                        {9'($urandom_range(0, 511)), count[COUNT_W-1:0]});
            stage_write(CSR_HEADING_ZERO, CSR_DATA_W'($urandom_range(0, 4095)));
            stage_write(CSR_HEADING_ONE, CSR_DATA_W'($urandom_range(0, 4095)));
            stage_write(CSR_HEADING_TWO, CSR_DATA_W'($urandom_range(0, 4095)));
            stage_write(CSR_HEADING_THREE, CSR_DATA_W'($urandom_range(0, 4095)));
         end
         if ($urandom_range(0, 2) == 0) stage_write(CSR_SPARE_SEVEN, CSR_DATA_W'($urandom()));
         stage_write(CSR_SWITCH_MARGIN, CSR_DATA_W'(margin));
         apply_writes();

         sent = 0;
         while (sent < per_phase) begin
            if ($urandom_range(0, 9) < 7) begin
               // A veering wind with jittering speed exercises the dead-band.
               dir      = $urandom_range(0, FULL_TENTHS - 1);
               spd      = $urandom_range(160, 4095);
               len      = $urandom_range(4, 16);
               step_max = $urandom_range(5, 60);
               for (k = 0; k < len; k++) begin
                  send_report(DIR_W'(dir), WSPEED_W'(spd), k == 0 && $urandom_range(0, 3) == 0);
                  dir = dir + $urandom_range(0, 2 * step_max) - step_max;
                  spd = spd + $urandom_range(0, 64) - 32;
                  if (spd < 0) spd = 0;
                  if (spd > 4095) spd = 4095;
               end
               sent += len;
            end else begin
               send_report(DIR_W'($urandom()), WSPEED_W'($urandom()),
                           $urandom_range(0, 9) == 0);
               sent++;
            end
         end
      end
   endtask

   function automatic void check_field(input string name, input logic [HDG_W-1:0] want,
                                       input logic [HDG_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      runway_pick_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_picks.size() == 0) begin
            $error("result beat with nothing expected: heading %0d",
                   rsp_bus.active_heading);
            mismatch_count++;
         end else begin
            want = pending_picks.pop_front();
            check_field("active_slot", HDG_W'(want.slot), HDG_W'(rsp_bus.active_slot));
            check_field("active_heading", want.heading, rsp_bus.active_heading);
            check_field("changed", HDG_W'(want.changed), HDG_W'(rsp_bus.changed));
            check_field("held", HDG_W'(want.held), HDG_W'(rsp_bus.held));
         end
      end
   end

   initial begin : result_receiver
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            while (rsp_hold > 0) begin
               @(posedge clock);
               rsp_hold--;
            end
         end else begin
            stall = draw_wait(rsp_steady);
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_RUNWAY_COUNT;
      csr_data           <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.wind_dir   <= '0;
      req_bus.wind_speed <= '0;
      req_bus.restart    <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_dead_band();
      test_register_corners();
      test_output_backpressure();
      test_random_traffic(880);

      wait_idle();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/wrs_pkg.sv
rtl/core/wrs_req_if.sv
rtl/core/wrs_rsp_if.sv
rtl/core/wrs_sine.sv
rtl/core/wind_runway_selector.sv
rtl/core/wrs_checker.sv
sim/wind_runway_selector_tb.sv
